// ===== src/vdpg_pkg.sv =====
package vdpg_pkg;

    // Input item: one display byte with its cell row and fetched font row.
    typedef struct packed {
        logic [7:0] display_byte;
        logic [3:0] cell_row;
        logic [7:0] font_bits;
    } t_in_item;

    // Result item: one group of eight palette indices, leftmost first.
    typedef struct packed {
        logic [3:0] pixel_0;
        logic [3:0] pixel_1;
        logic [3:0] pixel_2;
        logic [3:0] pixel_3;
        logic [3:0] pixel_4;
        logic [3:0] pixel_5;
        logic [3:0] pixel_6;
        logic [3:0] pixel_7;
        logic       last_group;
    } t_out_item;

    // Horizontal repeat of the source pixels held in a queue entry.
    typedef enum logic [1:0] {
        REP_1,
        REP_2,
        REP_4
    } t_rep;

    // Classified work for the back end: up to eight source pixels.
    typedef struct packed {
        logic [7:0][3:0] src;
        t_rep            rep;
        logic            two_groups;
    } t_entry;

    // Queue status seen by the front and back ends.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_GRAPHICS_ENABLE     = 3'd0;
    localparam logic [2:0] CFG_GRAPHICS_MODE       = 3'd1;
    localparam logic [2:0] CFG_SEMIGRAPHICS_ENABLE = 3'd2;
    localparam logic [2:0] CFG_EXTERNAL_SELECT     = 3'd3;
    localparam logic [2:0] CFG_COLOR_SET           = 3'd4;
    localparam logic [2:0] CFG_INVERT_TEXT         = 3'd5;

    // Graphics modes with special widths.
    localparam logic [2:0] GMODE_CG_WIDE = 3'd0;
    localparam logic [2:0] GMODE_RG_FULL = 3'd7;

    // Palette indices.
    localparam logic [3:0] PAL_GREEN      = 4'd0;
    localparam logic [3:0] PAL_BUFF       = 4'd4;
    localparam logic [3:0] PAL_BLACK      = 4'd8;
    localparam logic [3:0] PAL_DARK_GREEN = 4'd9;
    localparam logic [3:0] PAL_DARK_RED   = 4'd10;
    localparam logic [3:0] PAL_TEXT_ORANGE = 4'd11;

    // Text color for a {color_set, invert} selector.
    function automatic logic [3:0] text_color(input logic [1:0] sel);
        logic [3:0] c;
        case (sel)
            2'd0:    c = PAL_GREEN;
            2'd1:    c = PAL_DARK_GREEN;
            2'd2:    c = PAL_TEXT_ORANGE;
            default: c = PAL_DARK_RED;
        endcase
        return c;
    endfunction

    // Half-cell block pattern: left half, right half.
    function automatic logic [7:0] block_bits(input logic left_on, input logic right_on);
        return {{4{left_on}}, {4{right_on}}};
    endfunction

endpackage

// ===== src/vdpg_front.sv =====
module vdpg_front
    import vdpg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_in_item    i_item,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [2:0]  i_cfg_data,
    input  t_queue_stat i_stat,
    output logic        o_push,
    output t_entry      o_entry
);

    logic       r_graphics_enable;
    logic [2:0] r_graphics_mode;
    logic       r_semigraphics_enable;
    logic       r_external_select;
    logic       r_color_set;
    logic       r_invert_text;

    // Configuration registers; writes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_graphics_enable     <= 1'b0;
            r_graphics_mode       <= 3'd0;
            r_semigraphics_enable <= 1'b0;
            r_external_select     <= 1'b0;
            r_color_set           <= 1'b0;
            r_invert_text         <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GRAPHICS_ENABLE:     r_graphics_enable     <= i_cfg_data[0];
                CFG_GRAPHICS_MODE:       r_graphics_mode       <= i_cfg_data;
                CFG_SEMIGRAPHICS_ENABLE: r_semigraphics_enable <= i_cfg_data[0];
                CFG_EXTERNAL_SELECT:     r_external_select     <= i_cfg_data[0];
                CFG_COLOR_SET:           r_color_set           <= i_cfg_data[0];
                CFG_INVERT_TEXT:         r_invert_text         <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_push = i_start && !i_stat.full;

    // Classify the item into source pixels and a repeat factor.
    always_comb begin
        logic [7:0] data;
        logic [3:0] row;
        logic [7:0] pat;
        logic [3:0] fore;
        logic [3:0] back;
        logic [1:0] col;
        data = i_item.display_byte;
        row  = i_item.cell_row;
        pat  = 8'h00;
        fore = PAL_BLACK;
        back = PAL_BLACK;
        col  = {r_color_set, r_invert_text};
        o_entry = '0;
        o_entry.rep = REP_1;
        o_entry.two_groups = 1'b0;

        if (r_graphics_enable) begin
            if (!r_graphics_mode[0]) begin
                // Color graphics: 2-bit pixels, msb pair leftmost.
                for (int i = 0; i < 4; i++) begin
                    o_entry.src[7 - i] = {1'b0, r_color_set, data[7 - 2 * i -: 2]};
                    o_entry.src[3 - i] = {1'b0, r_color_set, data[7 - 2 * i -: 2]};
                end
                o_entry.rep = (r_graphics_mode == GMODE_CG_WIDE) ? REP_4 : REP_2;
                o_entry.two_groups = (r_graphics_mode == GMODE_CG_WIDE);
            end else begin
                // Resolution graphics: one bit per pixel.
                for (int i = 0; i < 8; i++) begin
                    if (data[7 - i]) begin
                        o_entry.src[7 - i] = r_color_set ? PAL_BUFF : PAL_GREEN;
                    end else begin
                        o_entry.src[7 - i] = r_color_set ? PAL_BLACK : PAL_DARK_GREEN;
                    end
                end
                o_entry.rep = (r_graphics_mode == GMODE_RG_FULL) ? REP_1 : REP_2;
                o_entry.two_groups = (r_graphics_mode != GMODE_RG_FULL);
            end
        end else begin
            if (!r_semigraphics_enable) begin
                // Text: internal font shows only rows 2 to 9.
                fore = text_color(col);
                back = text_color(col ^ 2'd1);
                if (r_external_select) begin
                    pat = (row <= 4'd11) ? i_item.font_bits : 8'h00;
                end else begin
                    pat = (row >= 4'd2 && row <= 4'd9) ? i_item.font_bits : 8'h00;
                end
            end else if (r_external_select) begin
                // Semigraphics-6: three bands of four rows.
                fore = {1'b0, r_color_set, data[7:6]};
                if (row < 4'd4) begin
                    pat = block_bits(data[5], data[4]);
                end else if (row < 4'd8) begin
                    pat = block_bits(data[3], data[2]);
                end else if (row < 4'd12) begin
                    pat = block_bits(data[1], data[0]);
                end
            end else begin
                // Semigraphics-4: two bands of six rows.
                fore = {1'b0, data[6:4]};
                if (row < 4'd6) begin
                    pat = block_bits(data[3], data[2]);
                end else if (row < 4'd12) begin
                    pat = block_bits(data[1], data[0]);
                end
            end
            for (int i = 0; i < 8; i++) begin
                o_entry.src[7 - i] = pat[7 - i] ? fore : back;
            end
        end
    end

endmodule

// ===== src/vdpg_queue.sv =====
module vdpg_queue
    import vdpg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_entry      i_entry,
    input  logic        i_pop,
    output t_entry      o_head,
    output t_queue_stat o_stat
);

    localparam logic [QUEUE_AW:0] FULL_COUNT = (QUEUE_AW + 1)'(QUEUE_DEPTH);

    t_entry                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == FULL_COUNT);
    assign o_stat.empty = (r_count == '0);

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");
`endif

endmodule

// ===== src/vdpg_back.sv =====
module vdpg_back
    import vdpg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_entry      i_head,
    input  t_queue_stat i_stat,
    output logic        o_pop,
    output logic        o_strobe,
    output t_out_item   o_result
);

    logic       r_half;
    logic       n_half;
    logic       r_strobe;
    t_out_item  r_result;
    t_out_item  n_result;
    logic [7:0][3:0] pix;

    // Pop the head once its last group goes out.
    always_comb begin
        o_pop  = !i_stat.empty && (r_half || !i_head.two_groups);
        n_half = !i_stat.empty && i_head.two_groups && !r_half;
    end

    // Expand the source pixels of the current group.
    always_comb begin
        logic [2:0] idx;
        logic [2:0] j;
        pix = '0;
        for (int k = 0; k < 8; k++) begin
            j = 3'(k);
            case (i_head.rep)
                REP_1:   idx = j;
                REP_2:   idx = {r_half, j[2:1]};
                REP_4:   idx = {1'b0, r_half, j[2]};
                default: idx = j;
            endcase
            pix[7 - k] = i_head.src[3'd7 - idx];
        end
        n_result.pixel_0    = pix[7];
        n_result.pixel_1    = pix[6];
        n_result.pixel_2    = pix[5];
        n_result.pixel_3    = pix[4];
        n_result.pixel_4    = pix[3];
        n_result.pixel_5    = pix[2];
        n_result.pixel_6    = pix[1];
        n_result.pixel_7    = pix[0];
        n_result.last_group = r_half || !i_head.two_groups;
    end

    // Control state of the emitter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_half   <= n_half;
            r_strobe <= !i_stat.empty;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

`ifndef NO_ASSERTIONS
    a_half_holds_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> !i_stat.empty)
        else $error("second group without a queued entry");
    a_second_group_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last_group) |=> (o_strobe && o_result.last_group))
        else $error("first group not followed by the last group");
`endif

endmodule

// ===== src/video_display_pixel_generator.sv =====
// Pixel generator for a character/graphics display controller.
// Input channel: present an item on i_item with start high; it is
// transferred at a rising edge where start is high and busy is low.
// Each item is classified at once from the configuration registers and
// placed in a four-entry queue; busy is high only while that queue is full.
// Output channel: each eight-pixel group appears on o_result for exactly one
// cycle with o_strobe high; last_group marks the final group of an item.
// The first group of an item passes through its queue entry and then the
// result register before it reaches the outputs, behind any items that
// were already queued.
// Throughput: the back end gives one group per cycle while the queue holds
// entries; an item has two groups in wide CG and non-full RG modes, else one.
// Configuration: write register i_cfg_index with i_cfg_data when i_cfg_valid
// is high; o_cfg_ready is always high. Indexes beyond the list are ignored.
// Write only while no item is in flight.
// Reset (synchronous, active low) empties the queue and clears all
// configuration registers. The receiver cannot stall; groups are never held.
module video_display_pixel_generator
    import vdpg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_in_item   i_item,
    output logic       o_strobe,
    output t_out_item  o_result,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [2:0] i_cfg_data
);

    t_queue_stat stat;
    t_entry      push_entry;
    t_entry      head;
    logic        push;
    logic        pop;

    assign busy        = stat.full;
    assign o_cfg_ready = 1'b1;

    // Front end: registers and classification.
    vdpg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (stat),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    // Queue between front and back.
    vdpg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (stat)
    );

    // Back end: group expansion and output register.
    vdpg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_stat   (stat),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
